// ===== src/ccnet_pkg.sv =====
// Package with the shared types, constants and the CRC byte step of the frame CRC engine.
`timescale 1ns / 1ps

package ccnet_pkg;

  // Kind of an incoming request.
  localparam logic KindTx = 1'b0;
  localparam logic KindRx = 1'b1;

  // Kind of a result request.
  localparam logic RkByte   = 1'b0;
  localparam logic RkStatus = 1'b1;

  localparam logic [15:0] CrcPoly = 16'h8408;
  localparam logic [7:0]  SyncA   = 8'd2;
  localparam logic [7:0]  SyncB   = 8'd192;
  localparam logic [7:0]  CntMax  = 8'hFF;
  localparam logic [7:0]  LenAdd  = 8'd2;
  localparam logic [7:0]  IdxSync = 8'd0;
  localparam logic [7:0]  IdxLen  = 8'd1;
  localparam logic [7:0]  MinLen  = 8'd2;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StSync = 2'd1,
    StLen  = 2'd2,
    StCrc  = 2'd3
  } status_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       frame_end;
    logic [7:0] message_size;
  } item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] out_byte;
    status_e    status;
    logic       run_end;
  } res_t;

  // Up to three results caused by one request, entry 0 goes out first.
  typedef struct packed {
    logic [1:0]      num;
    res_t [2:0]      res;
  } res_set_t;

  // One byte step of the reflected CRC-16, least significant bit first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/ccnet_core.sv =====
// Frame state registers and the per-byte framing, CRC and check logic.
`timescale 1ns / 1ps

module ccnet_core import ccnet_pkg::*; #(
  parameter int unsigned MAX_RX_BYTES = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  item_t    item_i,
  output res_set_t res_set_o
);

  localparam logic [7:0] MaxRx = 8'(MAX_RX_BYTES);

  logic [15:0] crc_q, crc_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  len_q, len_d;
  logic        sf_q, sf_d;

  logic        sync_bad;
  logic        tx_pass;
  logic [7:0]  feed_byte;
  logic [7:0]  cnt_inc;
  logic [15:0] crc_new;
  logic [1:0]  num;
  res_t [2:0]  res;
  status_e     rx_status;

  always_comb begin
    sync_bad  = (cnt_q == IdxSync) && (item_i.data_byte != SyncA) &&
                (item_i.data_byte != SyncB);
    tx_pass   = (item_i.kind == KindTx) && !sync_bad && !sf_q;
    feed_byte = item_i.data_byte;
    if (tx_pass && (cnt_q == IdxLen)) begin
      feed_byte = item_i.message_size + LenAdd;
    end
    crc_new = crc_feed(crc_q, feed_byte);
    cnt_inc = (cnt_q != CntMax) ? cnt_q + 8'd1 : cnt_q;

    crc_d = crc_q;
    len_d = len_q;
    sf_d  = sf_q || sync_bad;
    if (tx_pass || (item_i.kind == KindRx)) begin
      crc_d = crc_new;
      if (cnt_q == IdxLen) begin
        len_d = feed_byte;
      end
    end

    if ((cnt_inc < MinLen) || (cnt_inc != len_d) || (cnt_inc > MaxRx)) begin
      rx_status = StLen;
    end else if (sf_d) begin
      rx_status = StSync;
    end else if (crc_d != 16'h0000) begin
      rx_status = StCrc;
    end else begin
      rx_status = StOk;
    end

    res = '0;
    num = 2'd0;
    if (item_i.kind == KindTx) begin
      if (sync_bad) begin
        res[0].result_kind = RkStatus;
        res[0].status      = StSync;
        num                = 2'd1;
      end else if (tx_pass) begin
        res[0].out_byte = feed_byte;
        num             = 2'd1;
        if (item_i.frame_end) begin
          res[1].out_byte = crc_new[7:0];
          res[2].out_byte = crc_new[15:8];
          num             = 2'd3;
        end
      end
    end else if (item_i.frame_end) begin
      res[0].result_kind = RkStatus;
      res[0].status      = rx_status;
      num                = 2'd1;
    end
    for (int i = 0; i < 3; i++) begin
      res[i].run_end = (num == 2'(i + 1));
    end

    cnt_d = cnt_inc;
    if (item_i.frame_end) begin
      crc_d = '0;
      cnt_d = '0;
      len_d = '0;
      sf_d  = 1'b0;
    end
  end

  assign res_set_o.num = num;
  assign res_set_o.res = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
      cnt_q <= '0;
      len_q <= '0;
      sf_q  <= 1'b0;
    end else if (fire_i) begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
      len_q <= len_d;
      sf_q  <= sf_d;
    end
  end

endmodule

// ===== src/ccnet_res_buf.sv =====
// Three-entry result register that hands the results of one request out in order.
`timescale 1ns / 1ps

module ccnet_res_buf import ccnet_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  res_set_t res_set_i,
  output logic     load_ok_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output res_t     head_o
);

  logic [1:0] cnt_q, cnt_d;
  res_t [2:0] ent_q, ent_d;
  logic       pop;

  assign pop       = (cnt_q != 2'd0) && !out_stall_i;
  assign load_ok_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  always_comb begin
    cnt_d = cnt_q;
    ent_d = ent_q;
    if (load_i) begin
      cnt_d = res_set_i.num;
      ent_d = res_set_i.res;
    end else if (pop) begin
      cnt_d    = cnt_q - 2'd1;
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign head_o      = ent_q[0];

endmodule

// ===== src/ccnet_frame_crc_engine_unit.sv =====
// Top level of the frame CRC engine: input register, frame core and result register.
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// -------   ------------------------   ---------------------------------------------
// in        in_valid_i / in_stall_o    kind_i, data_byte_i, frame_end_i, message_size_i
// out       out_valid_o / out_stall_i  result_kind_o, out_byte_o, status_o, run_end_o
//
// Each input request waits in the input register until its results can load; the frame core then turns it
// into zero to three results in the same cycle that loads them into the result register.
// Requests with one result or none stream back to back while the output does not stall;
// a transmit frame end gives three results and holds the next request until only one is left.
// The limit is the single output port draining the three-entry result register.
// Reset is asynchronous and active low; it clears the frame state (CRC, byte count,
// length byte, sync flag) and empties both registers. A stall on the output only holds
// the result register, and the input stalls once it holds a request that cannot load.

module ccnet_frame_crc_engine_unit import ccnet_pkg::*; #(
  parameter int unsigned MAX_RX_BYTES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] data_byte_i,
  input  logic       frame_end_i,
  input  logic [7:0] message_size_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       result_kind_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       run_end_o
);

  // Input register: one request waits here until the result register can take its results.
  logic     in_vld_q;
  item_t    item_q;
  logic     load_ok;
  logic     fire;
  logic     take;
  res_set_t res_set;
  res_t     head;

  assign fire       = in_vld_q && load_ok;
  assign in_stall_o = in_vld_q && !load_ok;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  // The payload needs no reset; it is only read while the valid flag is set.
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.kind         <= kind_i;
      item_q.data_byte    <= data_byte_i;
      item_q.frame_end    <= frame_end_i;
      item_q.message_size <= message_size_i;
    end
  end

  // Frame core: CRC step, length byte rewrite, sync and receive checks.
  ccnet_core #(
    .MAX_RX_BYTES(MAX_RX_BYTES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .res_set_o(res_set)
  );

  // Result register: loads all results of a request at once and sends them one per cycle unless the output stalls.
  ccnet_res_buf u_res_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .res_set_i  (res_set),
    .load_ok_o  (load_ok),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .head_o     (head)
  );

  assign result_kind_o = head.result_kind;
  assign out_byte_o    = head.out_byte;
  assign status_o      = head.status;
  assign run_end_o     = head.run_end;

endmodule
